// ----- hdl/srd_pkg.sv -----
// shared constants and types for the signed rounding divider
// no dependencies
`default_nettype none

package srd_pkg;

   // operand and result width
   localparam int DATA_WIDTH = 32;

   // one beat of work as it moves down the divider stages
   typedef struct packed {
      logic [DATA_WIDTH-1:0] rem;   // partial remainder
      logic [DATA_WIDTH-1:0] nq;    // dividend bits still to use, quotient bits shifted in
      logic [DATA_WIDTH-1:0] den;   // divisor magnitude
      logic                  neg;   // result takes a minus sign
      logic                  dz;    // divisor was zero
   } div_work_type;

   // rounded magnitude with the flags it still needs
   typedef struct packed {
      logic [DATA_WIDTH-1:0] qmag;
      logic                  neg;
      logic                  dz;
   } round_work_type;

endpackage

`default_nettype wire

// ----- hdl/srd_if.sv -----
// valid/ready channel interfaces for the request and response beats
// depends on srd_pkg
`default_nettype none

interface srd_req_if
   import srd_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] dividend;
   logic signed [DATA_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface srd_rsp_if
   import srd_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quotient;
   logic                         div_by_zero;

   modport source (output valid, output quotient, output div_by_zero, input ready);
   modport sink   (input valid, input quotient, input div_by_zero, output ready);
endinterface

`default_nettype wire

// ----- hdl/srd_prep.sv -----
// entry stage: operand magnitudes, result sign and zero-divisor flag
// depends on srd_pkg
`default_nettype none

module srd_prep
   import srd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire logic [DATA_WIDTH-1:0] dividend,
   input  wire logic [DATA_WIDTH-1:0] divisor,
   output logic                       out_valid,
   output div_work_type               out_work
);

   logic         valid_ff;
   div_work_type work_ff, work_in;
   logic         nn, dn;

   // unsigned magnitudes; the most negative value maps to its own pattern
   always_comb begin
      nn            = dividend[DATA_WIDTH-1];
      dn            = divisor[DATA_WIDTH-1];
      work_in.rem   = '0;
      work_in.nq    = nn ? (~dividend + 1'b1) : dividend;
      work_in.den   = dn ? (~divisor + 1'b1) : divisor;
      work_in.neg   = nn ^ dn;
      work_in.dz    = (divisor == '0);
   end

   // valid register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

`default_nettype wire

// ----- hdl/srd_div_stage.sv -----
// one restoring division step: one quotient bit per stage
// depends on srd_pkg
`default_nettype none

module srd_div_stage
   import srd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic         in_valid,
   input  div_work_type      in_work,
   output logic              out_valid,
   output div_work_type      out_work
);

   logic                  valid_ff;
   div_work_type          work_ff, work_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH-1:0] diff;
   logic                  fits;

   // shift in the next dividend bit and try to take off the divisor
   // when it fits the difference is below the divisor, so the low bits hold it
   always_comb begin
      trial   = {in_work.rem, in_work.nq[DATA_WIDTH-1]};
      diff    = trial[DATA_WIDTH-1:0] - in_work.den;
      fits    = (trial >= {1'b0, in_work.den});
      work_in = in_work;
      work_in.rem = fits ? diff : trial[DATA_WIDTH-1:0];
      work_in.nq  = {in_work.nq[DATA_WIDTH-2:0], fits};
   end

   // valid register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

`default_nettype wire

// ----- hdl/srd_finish.sv -----
// rounding stage and output register: half away from zero, sign, saturation
// depends on srd_pkg
`default_nettype none

module srd_finish
   import srd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  div_work_type               in_work,
   output logic                       out_valid,
   output logic [DATA_WIDTH-1:0]      quotient,
   output logic                       div_by_zero
);

   localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic                  rnd_valid_ff;
   round_work_type        rnd_ff, rnd_in;
   logic                  round_up;
   logic                  out_valid_ff;
   logic [DATA_WIDTH-1:0] quot_ff, quot_in;
   logic                  dz_ff;

   // round up when twice the remainder reaches the divisor
   always_comb begin
      round_up    = ({in_work.rem, 1'b0} >= {1'b0, in_work.den});
      rnd_in.qmag = in_work.nq + {{(DATA_WIDTH-1){1'b0}}, round_up};
      rnd_in.neg  = in_work.neg;
      rnd_in.dz   = in_work.dz;
   end

   // apply sign; a zero divisor gives zero and a positive magnitude past the range saturates
   always_comb begin
      if (rnd_ff.dz) begin
         quot_in = '0;
      end else if (rnd_ff.neg) begin
         quot_in = ~rnd_ff.qmag + 1'b1;
      end else if (rnd_ff.qmag[DATA_WIDTH-1]) begin
         quot_in = MaxPos;
      end else begin
         quot_in = rnd_ff.qmag;
      end
   end

   // valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         rnd_valid_ff <= in_valid;
         out_valid_ff <= rnd_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         rnd_ff  <= rnd_in;
         quot_ff <= quot_in;
         dz_ff   <= rnd_ff.dz;
      end
   end

   assign out_valid   = out_valid_ff;
   assign quotient    = quot_ff;
   assign div_by_zero = dz_ff;

endmodule

`default_nettype wire

// ----- hdl/signed_rounding_divider.sv -----
// top level: pipelined signed divider with round-half-away-from-zero
// depends on srd_pkg, srd_if, srd_prep, srd_div_stage, srd_finish
//
//   channel   dir   beat contents                        handshake
//   req_chan  in    dividend, divisor (signed)            valid / ready
//   rsp_chan  out   quotient (signed), div_by_zero        valid / ready
//
// one beat enters per cycle while the pipe is not held; a result passes through the
// magnitude stage, one restoring stage per quotient bit, the rounding stage and the
// output register, in that order
// synchronous reset clears every valid bit; payload registers are not reset
// the whole pipe holds while the output register is full and not taken
`default_nettype none

module signed_rounding_divider
   import srd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   srd_req_if.sink    req_chan,
   srd_rsp_if.source  rsp_chan
);

   logic         advance;
   logic         stage_valid [DATA_WIDTH+1];
   div_work_type stage_work  [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] quot;

   // pipe moves when the output register is free or being emptied
   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   srd_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .dividend  (req_chan.dividend),
      .divisor   (req_chan.divisor),
      .out_valid (stage_valid[0]),
      .out_work  (stage_work[0])
   );

   // one stage per quotient bit, most significant first
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_div
      srd_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_work   (stage_work[i]),
         .out_valid (stage_valid[i+1]),
         .out_work  (stage_work[i+1])
      );
   end

   srd_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (stage_valid[DATA_WIDTH]),
      .in_work     (stage_work[DATA_WIDTH]),
      .out_valid   (rsp_chan.valid),
      .quotient    (quot),
      .div_by_zero (rsp_chan.div_by_zero)
   );

   assign rsp_chan.quotient = quot;

endmodule

`default_nettype wire

// ----- hdl/srd_checker.sv -----
// port-level checks on the signed rounding divider, bound to the top level
// depends on srd_pkg and the top level's channel interfaces
`default_nettype none

module srd_checker
   import srd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [DATA_WIDTH-1:0] rsp_quotient,
   input wire logic                  rsp_div_by_zero
);

   // a stalled result beat stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // a stalled result beat keeps its payload
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_quotient) && $stable(rsp_div_by_zero))
      else $error("response payload changed while stalled");

   // zero divisor always gives a zero quotient
   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_quotient == '0)
      else $error("quotient not zero on divide by zero");

   // requests are taken exactly when the output side can move
   a_ready_link : assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output stall");

   // nothing comes out straight after reset
   a_reset_empty : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind signed_rounding_divider srd_checker u_srd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_quotient    (rsp_chan.quotient),
   .rsp_div_by_zero (rsp_chan.div_by_zero)
);

`default_nettype wire
